@@ rtl/rpbu_pkg.sv @@
// Package for the RGB pixel blend unit: payload structs, action codes,
// register indexes and fixed widths. No dependencies.
package rpbu_pkg;

    localparam int CHAN_W   = 8;
    localparam int ACTION_W = 3;
    localparam int GAIN_W   = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [ACTION_W-1:0] ACT_MULTIPLY = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_SUBTRACT = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_SCREEN   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_OVERLAY  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_GREEN_OFS = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_RED_GAIN = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_GREEN_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RED_GAIN     = 2'd1;

    localparam logic [CHAN_W-1:0] GREEN_OFFSET_RST = 8'd200;
    localparam logic [GAIN_W-1:0] RED_GAIN_RST     = 4'd4;
    localparam logic [CHAN_W-1:0] CHAN_MAX         = 8'd255;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [CHAN_W-1:0]   a_red;
        logic [CHAN_W-1:0]   a_green;
        logic [CHAN_W-1:0]   a_blue;
        logic [CHAN_W-1:0]   b_red;
        logic [CHAN_W-1:0]   b_green;
        logic [CHAN_W-1:0]   b_blue;
    } t_blend_in;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
    } t_blend_out;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [CHAN_W-1:0]   a_red;
        logic [CHAN_W-1:0]   a_green;
        logic [CHAN_W-1:0]   a_blue;
    } t_merge_ctl;

endpackage

@@ rtl/rpbu_lane.sv @@
// One channel lane of the RGB pixel blend unit: registered 8x8 product,
// then a divide-by-255 with rounding. Depends on rpbu_pkg.
module rpbu_lane
    import rpbu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [CHAN_W-1:0] i_a,
    input  logic [CHAN_W-1:0] i_b,
    output logic [CHAN_W-1:0] o_mix
);

    logic [2*CHAN_W-1:0] r_prod, n_prod;
    logic                r_dbl, n_dbl;
    logic                r_inv, n_inv;
    logic                r_is_sub, n_is_sub;
    logic [CHAN_W-1:0]   r_sub, n_sub;

    logic [CHAN_W-1:0] op_a, op_b;

    // Pick operands: screen and the upper overlay half work on complements.
    always_comb begin
        op_a     = i_a;
        op_b     = i_b;
        n_dbl    = 1'b0;
        n_inv    = 1'b0;
        n_is_sub = (i_action == ACT_SUBTRACT);
        n_sub    = (i_a > i_b) ? (i_a - i_b) : '0;
        case (i_action)
            ACT_SCREEN: begin
                op_a  = ~i_a;
                op_b  = ~i_b;
                n_inv = 1'b1;
            end
            ACT_OVERLAY: begin
                n_dbl = 1'b1;
                if (i_b[CHAN_W-1]) begin
                    op_a  = ~i_a;
                    op_b  = ~i_b;
                    n_inv = 1'b1;
                end
            end
            default: ;
        endcase
        n_prod = op_a * op_b;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod   <= n_prod;
            r_dbl    <= n_dbl;
            r_inv    <= n_inv;
            r_is_sub <= n_is_sub;
            r_sub    <= n_sub;
        end
    end

    // floor((k*x + 255) / 510) == floor((k/2*x + 127) / 255).
    // Quotient estimate by x*257/65536 is low by at most one; fix with one compare.
    logic [17:0] num;
    logic [25:0] scaled;
    logic [9:0]  q_est;
    logic [17:0] rem;
    logic [9:0]  q_fix;
    logic [CHAN_W-1:0] q;

    always_comb begin
        num    = (r_dbl ? {1'b0, r_prod, 1'b0} : {2'b00, r_prod}) + 18'd127;
        scaled = {num, 8'd0} + {8'd0, num};
        q_est  = scaled[25:16];
        rem    = num - ({q_est, 8'd0} - {8'd0, q_est});
        q_fix  = (rem >= 18'd255) ? (q_est + 10'd1) : q_est;
        q      = q_fix[CHAN_W-1:0];
        if (r_is_sub) begin
            o_mix = r_sub;
        end else if (r_inv) begin
            o_mix = CHAN_MAX - q;
        end else begin
            o_mix = q;
        end
    end

endmodule

@@ rtl/rpbu_merge.sv @@
// Merge stage of the RGB pixel blend unit: joins the lane results into one
// pixel and handles the actions on pixel A alone. Depends on rpbu_pkg.
module rpbu_merge
    import rpbu_pkg::*;
(
    input  t_merge_ctl        i_ctl,
    input  logic [CHAN_W-1:0] i_mix_red,
    input  logic [CHAN_W-1:0] i_mix_green,
    input  logic [CHAN_W-1:0] i_mix_blue,
    input  logic [CHAN_W-1:0] i_green_offset,
    input  logic [GAIN_W-1:0] i_red_gain,
    output t_blend_out        o_pix
);

    logic [CHAN_W:0]        green_sum;
    logic [CHAN_W+GAIN_W-1:0] red_prod;

    always_comb begin
        green_sum = {1'b0, i_ctl.a_green} + {1'b0, i_green_offset};
        red_prod  = i_ctl.a_red * i_red_gain;
        o_pix.out_red   = i_ctl.a_red;
        o_pix.out_green = i_ctl.a_green;
        o_pix.out_blue  = i_ctl.a_blue;
        unique case (i_ctl.action) inside
            ACT_MULTIPLY, ACT_SUBTRACT, ACT_SCREEN, ACT_OVERLAY: begin
                o_pix.out_red   = i_mix_red;
                o_pix.out_green = i_mix_green;
                o_pix.out_blue  = i_mix_blue;
            end
            ACT_GREEN_OFS: begin
                o_pix.out_green = green_sum[CHAN_W] ? CHAN_MAX : green_sum[CHAN_W-1:0];
            end
            ACT_RED_GAIN: begin
                o_pix.out_red  = (red_prod[CHAN_W+GAIN_W-1:CHAN_W] != '0)
                                 ? CHAN_MAX : red_prod[CHAN_W-1:0];
                o_pix.out_blue = '0;
            end
            default: ;  // undefined actions pass pixel A through
        endcase
    end

endmodule

@@ rtl/rgb_pixel_blend_unit.sv @@
// RGB pixel blend unit top level: three channel lanes, merge stage, output
// register and configuration registers. Depends on rpbu_pkg, rpbu_lane, rpbu_merge.
//
// Blends two RGB pixels per transaction (multiply, subtract, screen, overlay)
// or adjusts pixel A alone (green offset, red gain). Throughput is one pixel
// per clock while the output is not stalled. The pipeline has two stages: the
// lane multipliers (one 8x8 product per channel) feed the stage-1 registers,
// and the divide-by-255, invert and merge logic feeds the output register,
// which drives output valid. Bubbles collapse, so input stall rises only when
// both stages hold a transaction and the output is stalled. Configuration
// writes are always accepted (ready tied high); write them only while idle.
// Index 0 is green_offset (reset 200), index 1 is red_gain (reset 4); other
// indexes are ignored.
module rgb_pixel_blend_unit
    import rpbu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_blend_in            i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_blend_out           o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CHAN_W-1:0]    i_cfg_data
);

    logic              r_v1, r_v2;
    t_merge_ctl        r_ctl1;
    t_blend_out        r_out;
    t_blend_out        n_out;
    logic [CHAN_W-1:0] r_green_offset;
    logic [GAIN_W-1:0] r_red_gain;
    logic              en1, en2;
    logic [CHAN_W-1:0] mix_red, mix_green, mix_blue;

    // Advance the output stage when it is empty or drained; advance stage 1
    // when it is empty or can move forward.
    assign en2 = !r_v2 || !i_out_stall;
    assign en1 = !r_v1 || en2;

    assign o_in_stall  = !en1;
    assign o_out_valid = r_v2;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_in_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // Hold pixel A and the action alongside the lane products.
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_ctl1.action  <= i_in_data.action;
            r_ctl1.a_red   <= i_in_data.a_red;
            r_ctl1.a_green <= i_in_data.a_green;
            r_ctl1.a_blue  <= i_in_data.a_blue;
        end
        if (en2) begin
            r_out <= n_out;
        end
    end

    // Configuration registers; drop writes to unknown indexes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_green_offset <= GREEN_OFFSET_RST;
            r_red_gain     <= RED_GAIN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_GREEN_OFFSET: r_green_offset <= i_cfg_data;
                REG_RED_GAIN:     r_red_gain     <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    rpbu_lane u_lane_red (
        .i_clk    (i_clk),
        .i_en     (en1),
        .i_action (i_in_data.action),
        .i_a      (i_in_data.a_red),
        .i_b      (i_in_data.b_red),
        .o_mix    (mix_red)
    );

    rpbu_lane u_lane_green (
        .i_clk    (i_clk),
        .i_en     (en1),
        .i_action (i_in_data.action),
        .i_a      (i_in_data.a_green),
        .i_b      (i_in_data.b_green),
        .o_mix    (mix_green)
    );

    rpbu_lane u_lane_blue (
        .i_clk    (i_clk),
        .i_en     (en1),
        .i_action (i_in_data.action),
        .i_a      (i_in_data.a_blue),
        .i_b      (i_in_data.b_blue),
        .o_mix    (mix_blue)
    );

    rpbu_merge u_merge (
        .i_ctl          (r_ctl1),
        .i_mix_red      (mix_red),
        .i_mix_green    (mix_green),
        .i_mix_blue     (mix_blue),
        .i_green_offset (r_green_offset),
        .i_red_gain     (r_red_gain),
        .o_pix          (n_out)
    );

endmodule
